// File: hdl/hgec_pkg.sv
// ----------------------------------------------------------------------------
// hgec_pkg: shared definitions of the hand gesture event classifier
// Gesture codes, field widths, register indexes, reset values and the
// result record that travels from the classifier front end to the queue.
// ----------------------------------------------------------------------------
package hgec_pkg;

   localparam int DEFAULT_TRAJ_DEPTH = 12;

   localparam int COORD_W   = 11;
   localparam int FINGER_W  = 3;
   localparam int AREA_W    = 17;
   localparam int ELAPSED_W = 10;
   localparam int GESTURE_W = 3;
   localparam int MS_W      = 16;
   localparam int THR_W     = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [GESTURE_W-1:0] G_NONE  = 3'd0;
   localparam logic [GESTURE_W-1:0] G_LEFT  = 3'd1;
   localparam logic [GESTURE_W-1:0] G_RIGHT = 3'd2;
   localparam logic [GESTURE_W-1:0] G_UP    = 3'd3;
   localparam logic [GESTURE_W-1:0] G_DOWN  = 3'd4;
   localparam logic [GESTURE_W-1:0] G_OPEN  = 3'd5;
   localparam logic [GESTURE_W-1:0] G_FIST  = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_MIN_DISTANCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN_MS        = 1'b1;

   localparam logic [THR_W-1:0]   RESET_SWIPE_MIN_DISTANCE = 8'd80;
   localparam logic [2*THR_W-1:0] RESET_SWIPE_MIN_SQ       = 16'd6400;
   localparam logic [MS_W-1:0]    RESET_COOLDOWN_MS        = 16'd600;
   localparam logic [MS_W-1:0]    RESET_SINCE_MS           = 16'd10000;

   localparam int MIN_SWIPE_POINTS = 4;

   typedef struct packed {
      logic [GESTURE_W-1:0] gesture;
      logic [GESTURE_W-1:0] latched_gesture;
   } result_type;

endpackage

// File: hdl/hgec_front.sv
// ----------------------------------------------------------------------------
// hgec_front: request intake and gesture decision
// Holds the centre window, the cooldown counter, the latched gesture and the
// configuration registers, and turns each accepted request into one result.
// ----------------------------------------------------------------------------
module hgec_front #(
   parameter int TRAJ_DEPTH = hgec_pkg::DEFAULT_TRAJ_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              hand_present,
   input  logic [hgec_pkg::COORD_W-1:0]      center_x,
   input  logic [hgec_pkg::COORD_W-1:0]      center_y,
   input  logic [hgec_pkg::FINGER_W-1:0]     finger_count,
   input  logic [hgec_pkg::AREA_W-1:0]       blob_area,
   input  logic [hgec_pkg::AREA_W-1:0]       hull_area,
   input  logic [hgec_pkg::ELAPSED_W-1:0]    elapsed_ms,
   input  logic                              csr_write,
   input  logic [hgec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hgec_pkg::CSR_DATA_W-1:0]   csr_data,
   output hgec_pkg::result_type              result
);
   import hgec_pkg::*;

   localparam int IDX_W = $clog2(TRAJ_DEPTH);
   localparam int CNT_W = $clog2(TRAJ_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRAJ_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TRAJ_DEPTH);
   localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(MIN_SWIPE_POINTS);

   logic [COORD_W-1:0] path_x_ff [TRAJ_DEPTH];
   logic [COORD_W-1:0] path_y_ff [TRAJ_DEPTH];

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [MS_W-1:0]      since_ff, since_in;
   logic [GESTURE_W-1:0] latched_ff, latched_in;
   logic [2*THR_W-1:0]   thr_sq_ff;
   logic [MS_W-1:0]      cooldown_ff;

   logic [2*THR_W-1:0]   thr_sq_new;
   logic [MS_W:0]        since_sum;
   logic [MS_W-1:0]      since_sat;
   logic [CNT_W-1:0]     push_count;
   logic [IDX_W-1:0]     push_tail;
   logic [IDX_W-1:0]     head_next;
   logic [IDX_W-1:0]     tail_next;
   logic [COORD_W-1:0]   old_x, old_y;
   logic signed [COORD_W:0] dx, dy, ndx, ndy;
   logic [COORD_W-1:0]   dx_mag, dy_mag;
   logic [2*COORD_W-1:0] dx_sq, dy_sq;
   logic [2*COORD_W:0]   dist_sq;
   logic [GESTURE_W-1:0] swipe, pose, found, gesture;
   logic [AREA_W+4:0]    area_25, hull_18;
   logic                 expired;

   assign thr_sq_new = csr_data[THR_W-1:0] * csr_data[THR_W-1:0];

   // Window bookkeeping for a push of the current centre.
   assign head_next  = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == IDX_LAST) ? '0 : tail_ff + 1'b1;
   assign push_count = (count_ff == CNT_FULL) ? count_ff : count_ff + 1'b1;
   assign push_tail  = (count_ff == CNT_FULL) ? tail_next : tail_ff;

   assign since_sum = {1'b0, since_ff} + (MS_W + 1)'(elapsed_ms);
   assign since_sat = since_sum[MS_W] ? '1 : since_sum[MS_W-1:0];
   assign expired   = since_sat >= cooldown_ff;

   // The newest point is the incoming centre; the oldest is read at the tail.
   assign old_x = path_x_ff[push_tail];
   assign old_y = path_y_ff[push_tail];
   assign dx  = $signed({1'b0, center_x}) - $signed({1'b0, old_x});
   assign dy  = $signed({1'b0, center_y}) - $signed({1'b0, old_y});
   assign ndx = -dx;
   assign ndy = -dy;
   assign dx_mag = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
   assign dy_mag = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
   assign dx_sq  = dx_mag * dx_mag;
   assign dy_sq  = dy_mag * dy_mag;
   assign dist_sq = (2*COORD_W + 1)'(dx_sq) + (2*COORD_W + 1)'(dy_sq);

   always_comb begin
      swipe = G_NONE;
      if (push_count >= CNT_MIN && dist_sq >= (2*COORD_W + 1)'(thr_sq_ff)) begin
         priority if (dx == 0 && dy == 0) begin
            swipe = G_RIGHT;
         end else if (dx > 0 && dy >= ndx && dy < dx) begin
            swipe = G_RIGHT;
         end else if (dy >= dx && dy > ndx) begin
            swipe = G_DOWN;
         end else if (dy <= dx && dy < ndx) begin
            swipe = G_UP;
         end else begin
            swipe = G_LEFT;
         end
      end
   end

   // Fist test blob*25 > hull*18, built from shifts and adds.
   assign area_25 = (AREA_W + 5)'({blob_area, 4'b0}) + (AREA_W + 5)'({blob_area, 3'b0})
                  + (AREA_W + 5)'(blob_area);
   assign hull_18 = (AREA_W + 5)'({hull_area, 4'b0}) + (AREA_W + 5)'({hull_area, 1'b0});

   always_comb begin
      priority if (finger_count >= FINGER_W'(4)) begin
         pose = G_OPEN;
      end else if (finger_count == '0 && area_25 > hull_18) begin
         pose = G_FIST;
      end else begin
         pose = G_NONE;
      end
   end

   assign found = (swipe != G_NONE) ? swipe : pose;

   always_comb begin
      count_in   = count_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      since_in   = since_ff;
      latched_in = latched_ff;
      gesture    = G_NONE;
      if (accept) begin
         since_in = since_sat;
         if (!hand_present) begin
            count_in = '0;
            head_in  = '0;
            tail_in  = '0;
         end else begin
            count_in = push_count;
            head_in  = head_next;
            tail_in  = push_tail;
            if (expired) begin
               if (found != G_NONE) begin
                  if (!(found == latched_ff && (found == G_OPEN || found == G_FIST))) begin
                     since_in   = '0;
                     latched_in = found;
                     count_in   = '0;
                     head_in    = '0;
                     tail_in    = '0;
                     gesture    = found;
                  end
               end else if (finger_count >= FINGER_W'(1) && finger_count <= FINGER_W'(3)) begin
                  latched_in = G_NONE;
               end
            end
         end
      end
   end

   assign result.gesture         = gesture;
   assign result.latched_gesture = latched_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         since_ff    <= RESET_SINCE_MS;
         latched_ff  <= G_NONE;
         thr_sq_ff   <= RESET_SWIPE_MIN_SQ;
         cooldown_ff <= RESET_COOLDOWN_MS;
      end else begin
         count_ff   <= count_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         since_ff   <= since_in;
         latched_ff <= latched_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_SWIPE_MIN_DISTANCE: thr_sq_ff   <= thr_sq_new;
               CSR_COOLDOWN_MS:        cooldown_ff <= csr_data[MS_W-1:0];
               default:                thr_sq_ff   <= thr_sq_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hand_present) begin
         path_x_ff[head_ff] <= center_x;
         path_y_ff[head_ff] <= center_y;
      end
   end

endmodule

// File: hdl/hgec_queue.sv
// ----------------------------------------------------------------------------
// hgec_queue: two-entry result queue
// Decouples the decision front end from the response channel so either side
// can stall without stopping the other.
// ----------------------------------------------------------------------------
module hgec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hgec_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output hgec_pkg::result_type out_data
);
   import hgec_pkg::*;

   result_type  entry_ff [2];
   logic        rd_ff, rd_in;
   logic        wr_ff, wr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        pop;

   assign out_valid = fill_ff != 2'd0;
   assign full      = fill_ff == 2'd2;
   assign out_data  = entry_ff[rd_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      rd_in   = pop  ? ~rd_ff : rd_ff;
      wr_in   = push ? ~wr_ff : wr_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff   <= 1'b0;
         wr_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/hand_gesture_event_classifier_top.sv
// ----------------------------------------------------------------------------
// hand_gesture_event_classifier_top: per-frame hand report to gesture code
// Front end keeps the centre window, cooldown and latched gesture and decides
// one gesture per request; a two-entry queue carries results to the output.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  hand report fields
//   rsp      out        rsp_valid/rsp_stall  gesture, latched_gesture
//   csr      in         csr_write            csr_index, csr_data
//
// A request is decided in the cycle it is accepted, so one request per cycle
// is taken unless the queue is full; its response is queued behind any earlier
// ones. The rate is set by the window update and swipe test in the front end.
// Reset is synchronous and active high; it restores register defaults, empties
// the window and the queue. The request side stalls only while both queue
// entries hold responses not yet taken.
//
module hand_gesture_event_classifier_top #(
   parameter int TRAJ_DEPTH = hgec_pkg::DEFAULT_TRAJ_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_hand_present,
   input  logic [hgec_pkg::COORD_W-1:0]      req_center_x,
   input  logic [hgec_pkg::COORD_W-1:0]      req_center_y,
   input  logic [hgec_pkg::FINGER_W-1:0]     req_finger_count,
   input  logic [hgec_pkg::AREA_W-1:0]       req_blob_area,
   input  logic [hgec_pkg::AREA_W-1:0]       req_hull_area,
   input  logic [hgec_pkg::ELAPSED_W-1:0]    req_elapsed_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hgec_pkg::GESTURE_W-1:0]    rsp_gesture,
   output logic [hgec_pkg::GESTURE_W-1:0]    rsp_latched_gesture,
   input  logic                              csr_write,
   input  logic [hgec_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hgec_pkg::CSR_DATA_W-1:0]   csr_data
);
   import hgec_pkg::*;

   logic       accept;
   logic       queue_full;
   result_type front_result;
   result_type queue_result;

   // The front end may take a request whenever the queue has a free entry.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   hgec_front #(
      .TRAJ_DEPTH(TRAJ_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .hand_present (req_hand_present),
      .center_x     (req_center_x),
      .center_y     (req_center_y),
      .finger_count (req_finger_count),
      .blob_area    (req_blob_area),
      .hull_area    (req_hull_area),
      .elapsed_ms   (req_elapsed_ms),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .result       (front_result)
   );

   // Every accepted request produces exactly one response entry.
   hgec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (queue_result)
   );

   assign rsp_gesture         = queue_result.gesture;
   assign rsp_latched_gesture = queue_result.latched_gesture;

endmodule
